// ----- sv/dsa_pkg.sv -----
`timescale 1ns / 1ps

package dsa_pkg;

    localparam int MOD_BITS = 31;
    localparam int CNT_W    = $clog2(MOD_BITS);
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_PRIME_P     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_Q     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GENERATOR_G = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRIVATE_X   = 2'd3;

    localparam logic [MOD_BITS-1:0] RST_P = MOD_BITS'(23);
    localparam logic [MOD_BITS-1:0] RST_Q = MOD_BITS'(11);
    localparam logic [MOD_BITS-1:0] RST_G = MOD_BITS'(2);
    localparam logic [MOD_BITS-1:0] RST_X = MOD_BITS'(3);

    typedef enum logic
    {
        OP_DIV,
        OP_MUL
    } arith_op_t;

    typedef struct packed
    {
        logic      start;
        arith_op_t op;
    } arith_req_t;

endpackage

// ----- sv/dsa_arith.sv -----
`timescale 1ns / 1ps

// Bit-serial modular unit.
// OP_DIV: a / m, quo and res = a mod m (res is 0 when m is 0).
// OP_MUL: a * b mod m, b below m (0 when m is 0), a doubling step and an add step per bit of a.
module dsa_arith import dsa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  arith_req_t          req,
    input  logic [MOD_BITS-1:0] a,
    input  logic [MOD_BITS-1:0] b,
    input  logic [MOD_BITS-1:0] m,
    output logic                done,
    output logic [MOD_BITS-1:0] res,
    output logic [MOD_BITS-1:0] quo
);

    typedef enum logic
    {
        A_IDLE,
        A_RUN
    } astate_t;

    astate_t             state_reg;
    arith_op_t           op_reg;
    logic [MOD_BITS-1:0] sh_reg;
    logic [MOD_BITS-1:0] b_reg;
    logic [MOD_BITS-1:0] m_reg;
    logic [MOD_BITS-1:0] acc_reg;
    logic [MOD_BITS-1:0] acc_next;
    logic                qbit;
    logic [CNT_W-1:0]    cnt_reg;
    logic                phase_reg;
    logic                done_reg;
    logic [MOD_BITS-1:0] res_reg;
    logic [MOD_BITS:0]   t;
    logic                last;

    always_comb
    begin
        qbit = 1'b0;
        if (op_reg == OP_DIV)
        begin
            t = {acc_reg, sh_reg[MOD_BITS-1]};
            if (t >= {1'b0, m_reg})
            begin
                t = t - {1'b0, m_reg};
                qbit = 1'b1;
            end
        end
        else
        begin
            if (!phase_reg)
                t = {acc_reg, 1'b0};
            else
                t = {1'b0, acc_reg} + (sh_reg[MOD_BITS-1] ? {1'b0, b_reg} : '0);
            if (t >= {1'b0, m_reg})
                t = t - {1'b0, m_reg};
        end
        acc_next = t[MOD_BITS-1:0];
        last = (cnt_reg == CNT_W'(MOD_BITS - 1)) && (op_reg == OP_DIV || phase_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
            op_reg    <= OP_DIV;
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                A_IDLE:
                begin
                    if (req.start)
                    begin
                        op_reg    <= req.op;
                        sh_reg    <= a;
                        b_reg     <= b;
                        m_reg     <= m;
                        acc_reg   <= '0;
                        cnt_reg   <= '0;
                        phase_reg <= 1'b0;
                        state_reg <= A_RUN;
                    end
                end
                A_RUN:
                begin
                    acc_reg <= acc_next;
                    if (op_reg == OP_DIV)
                        sh_reg <= {sh_reg[MOD_BITS-2:0], qbit};
                    else if (phase_reg)
                        sh_reg <= {sh_reg[MOD_BITS-2:0], 1'b0};
                    if (op_reg == OP_MUL)
                        phase_reg <= ~phase_reg;
                    if (op_reg == OP_DIV || phase_reg)
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    if (last)
                    begin
                        res_reg   <= (m_reg == '0) ? '0 : acc_next;
                        done_reg  <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                end
                default:
                    state_reg <= A_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;
    assign quo  = sh_reg;

endmodule

// ----- sv/dsa_sign_verify_unit.sv -----
`timescale 1ns / 1ps

// DSA sign / verify engine over moduli of up to 31 bits. One request at a time:
// a request is taken when in_ready is high and its result is held in output
// registers until out_ready, while the next request may already be taken.
// All multiplies and reductions run through one bit-serial modular unit; the
// modular add and subtract in the signing and inverse steps are combinational.
// An exponentiation is 31 squarings plus one multiply per set exponent bit; the
// inverse is an extended Euclid loop of one reduction and one multiply per
// quotient step (up to about 45 steps). A sign request needs two
// exponentiations and one inverse, a verify request three exponentiations and
// one inverse. When the inverse does not exist the request ends right after
// the public key and the inverse search. Configuration must be written by the
// user only while no request is in progress; the block does not enforce it.
module dsa_sign_verify_unit import dsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MOD_BITS-1:0]  cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [MOD_BITS-1:0]  hash_value,
    input  logic [MOD_BITS-1:0]  nonce_k,
    input  logic [MOD_BITS-1:0]  check_r,
    input  logic [MOD_BITS-1:0]  check_s,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [MOD_BITS-1:0]  public_key,
    output logic [MOD_BITS-1:0]  sig_r,
    output logic [MOD_BITS-1:0]  sig_s,
    output logic [MOD_BITS-1:0]  check_value,
    output logic                 valid_res,
    output logic                 status
);

    typedef enum logic [4:0]
    {
        S_IDLE, S_WAIT, S_GP,
        S_PSQ, S_PSQD, S_PMULD, S_PNEXT,
        S_Y, S_IV1, S_ILOOP, S_IDIV, S_IMUL, S_INVD,
        S_SR, S_SR2, S_HQ, S_XR, S_SS,
        S_U1, S_U2, S_A1, S_A2, S_PROD, S_V,
        S_FIN
    } state_t;

    state_t state_reg, ret_reg, pret_reg;

    logic [MOD_BITS-1:0] p_reg, q_reg, g_reg, x_reg;
    logic                func_reg;
    logic [MOD_BITS-1:0] h_reg, k_reg, cr_reg, cs_reg;
    logic [MOD_BITS-1:0] gp_reg, y_reg, inv_reg, sr_reg, ss_reg, v_reg;
    logic [MOD_BITS-1:0] tmp_reg, u2_reg, a1_reg;
    logic                ok_reg, valid_reg, stat_reg;
    logic [MOD_BITS-1:0] pbase_reg, pexp_reg, pacc_reg;
    logic [CNT_W-1:0]    pcnt_reg;
    logic [MOD_BITS-1:0] r0_reg, r1_reg, t0_reg, t1_reg;

    arith_req_t          req_reg;
    logic [MOD_BITS-1:0] oa_reg, ob_reg, om_reg;
    logic                ar_done;
    logic [MOD_BITS-1:0] ar_res, ar_quo;

    logic                ovalid_reg;
    logic [MOD_BITS-1:0] o_y_reg, o_r_reg, o_s_reg, o_v_reg;
    logic                o_valid_reg, o_stat_reg;

    logic [MOD_BITS:0]   sum;
    logic [MOD_BITS-1:0] nt;
    logic [MOD_BITS-1:0] one_p;

    dsa_arith u_arith
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .a     (oa_reg),
        .b     (ob_reg),
        .m     (om_reg),
        .done  (ar_done),
        .res   (ar_res),
        .quo   (ar_quo)
    );

    always_comb
    begin
        sum = {1'b0, tmp_reg} + {1'b0, ar_res};
        if (sum >= {1'b0, q_reg})
            sum = sum - {1'b0, q_reg};
        if (t0_reg >= ar_res)
            nt = t0_reg - ar_res;
        else
            nt = MOD_BITS'({1'b0, t0_reg} + {1'b0, q_reg} - {1'b0, ar_res});
        one_p = (p_reg > MOD_BITS'(1)) ? MOD_BITS'(1) : '0;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            pret_reg   <= S_IDLE;
            req_reg    <= '{start: 1'b0, op: OP_DIV};
            ovalid_reg <= 1'b0;
            p_reg      <= RST_P;
            q_reg      <= RST_Q;
            g_reg      <= RST_G;
            x_reg      <= RST_X;
        end
        else
        begin
            req_reg.start <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PRIME_P:     p_reg <= cfg_data;
                    REG_ORDER_Q:     q_reg <= cfg_data;
                    REG_GENERATOR_G: g_reg <= cfg_data;
                    REG_PRIVATE_X:   x_reg <= cfg_data;
                    default:         p_reg <= p_reg;
                endcase
            end
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        func_reg <= func;
                        h_reg    <= hash_value;
                        k_reg    <= nonce_k;
                        cr_reg   <= check_r;
                        cs_reg   <= check_s;
                        req_reg  <= '{start: 1'b1, op: OP_DIV};
                        oa_reg   <= g_reg;
                        om_reg   <= p_reg;
                        ret_reg  <= S_GP;
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (ar_done)
                        state_reg <= ret_reg;
                end
                S_GP:
                begin
                    gp_reg    <= ar_res;
                    pbase_reg <= ar_res;
                    pexp_reg  <= x_reg;
                    pacc_reg  <= one_p;
                    pcnt_reg  <= CNT_W'(MOD_BITS - 1);
                    pret_reg  <= S_Y;
                    state_reg <= S_PSQ;
                end
                S_PSQ:
                begin
                    req_reg   <= '{start: 1'b1, op: OP_MUL};
                    oa_reg    <= pacc_reg;
                    ob_reg    <= pacc_reg;
                    om_reg    <= p_reg;
                    ret_reg   <= S_PSQD;
                    state_reg <= S_WAIT;
                end
                S_PSQD:
                begin
                    pacc_reg <= ar_res;
                    if (pexp_reg[MOD_BITS-1])
                    begin
                        req_reg   <= '{start: 1'b1, op: OP_MUL};
                        oa_reg    <= ar_res;
                        ob_reg    <= pbase_reg;
                        om_reg    <= p_reg;
                        ret_reg   <= S_PMULD;
                        state_reg <= S_WAIT;
                    end
                    else
                        state_reg <= S_PNEXT;
                end
                S_PMULD:
                begin
                    pacc_reg  <= ar_res;
                    state_reg <= S_PNEXT;
                end
                S_PNEXT:
                begin
                    pexp_reg <= {pexp_reg[MOD_BITS-2:0], 1'b0};
                    if (pcnt_reg == '0)
                        state_reg <= pret_reg;
                    else
                    begin
                        pcnt_reg  <= pcnt_reg - CNT_W'(1);
                        state_reg <= S_PSQ;
                    end
                end
                S_Y:
                begin
                    y_reg <= pacc_reg;
                    if (q_reg < MOD_BITS'(2))
                    begin
                        ok_reg    <= 1'b0;
                        state_reg <= S_INVD;
                    end
                    else
                    begin
                        req_reg   <= '{start: 1'b1, op: OP_DIV};
                        oa_reg    <= func_reg ? cs_reg : k_reg;
                        om_reg    <= q_reg;
                        ret_reg   <= S_IV1;
                        state_reg <= S_WAIT;
                    end
                end
                S_IV1:
                begin
                    r0_reg    <= q_reg;
                    r1_reg    <= ar_res;
                    t0_reg    <= '0;
                    t1_reg    <= MOD_BITS'(1);
                    state_reg <= S_ILOOP;
                end
                S_ILOOP:
                begin
                    if (r1_reg == '0)
                    begin
                        ok_reg    <= (r0_reg == MOD_BITS'(1));
                        inv_reg   <= t0_reg;
                        state_reg <= S_INVD;
                    end
                    else
                    begin
                        req_reg   <= '{start: 1'b1, op: OP_DIV};
                        oa_reg    <= r0_reg;
                        om_reg    <= r1_reg;
                        ret_reg   <= S_IDIV;
                        state_reg <= S_WAIT;
                    end
                end
                S_IDIV:
                begin
                    tmp_reg   <= ar_res;
                    req_reg   <= '{start: 1'b1, op: OP_MUL};
                    oa_reg    <= ar_quo;
                    ob_reg    <= t1_reg;
                    om_reg    <= q_reg;
                    ret_reg   <= S_IMUL;
                    state_reg <= S_WAIT;
                end
                S_IMUL:
                begin
                    r0_reg    <= r1_reg;
                    r1_reg    <= tmp_reg;
                    t0_reg    <= t1_reg;
                    t1_reg    <= nt;
                    state_reg <= S_ILOOP;
                end
                S_INVD:
                begin
                    sr_reg    <= '0;
                    ss_reg    <= '0;
                    v_reg     <= '0;
                    valid_reg <= 1'b0;
                    stat_reg  <= ~ok_reg;
                    if (!ok_reg)
                        state_reg <= S_FIN;
                    else if (!func_reg)
                    begin
                        pbase_reg <= gp_reg;
                        pexp_reg  <= k_reg;
                        pacc_reg  <= one_p;
                        pcnt_reg  <= CNT_W'(MOD_BITS - 1);
                        pret_reg  <= S_SR;
                        state_reg <= S_PSQ;
                    end
                    else
                    begin
                        req_reg   <= '{start: 1'b1, op: OP_MUL};
                        oa_reg    <= h_reg;
                        ob_reg    <= inv_reg;
                        om_reg    <= q_reg;
                        ret_reg   <= S_U1;
                        state_reg <= S_WAIT;
                    end
                end
                S_SR:
                begin
                    req_reg   <= '{start: 1'b1, op: OP_DIV};
                    oa_reg    <= pacc_reg;
                    om_reg    <= q_reg;
                    ret_reg   <= S_SR2;
                    state_reg <= S_WAIT;
                end
                S_SR2:
                begin
                    sr_reg    <= ar_res;
                    req_reg   <= '{start: 1'b1, op: OP_DIV};
                    oa_reg    <= h_reg;
                    om_reg    <= q_reg;
                    ret_reg   <= S_HQ;
                    state_reg <= S_WAIT;
                end
                S_HQ:
                begin
                    tmp_reg   <= ar_res;
                    req_reg   <= '{start: 1'b1, op: OP_MUL};
                    oa_reg    <= x_reg;
                    ob_reg    <= sr_reg;
                    om_reg    <= q_reg;
                    ret_reg   <= S_XR;
                    state_reg <= S_WAIT;
                end
                S_XR:
                begin
                    req_reg   <= '{start: 1'b1, op: OP_MUL};
                    oa_reg    <= inv_reg;
                    ob_reg    <= sum[MOD_BITS-1:0];
                    om_reg    <= q_reg;
                    ret_reg   <= S_SS;
                    state_reg <= S_WAIT;
                end
                S_SS:
                begin
                    ss_reg    <= ar_res;
                    state_reg <= S_FIN;
                end
                S_U1:
                begin
                    tmp_reg   <= ar_res;
                    req_reg   <= '{start: 1'b1, op: OP_MUL};
                    oa_reg    <= cr_reg;
                    ob_reg    <= inv_reg;
                    om_reg    <= q_reg;
                    ret_reg   <= S_U2;
                    state_reg <= S_WAIT;
                end
                S_U2:
                begin
                    u2_reg    <= ar_res;
                    pbase_reg <= gp_reg;
                    pexp_reg  <= tmp_reg;
                    pacc_reg  <= one_p;
                    pcnt_reg  <= CNT_W'(MOD_BITS - 1);
                    pret_reg  <= S_A1;
                    state_reg <= S_PSQ;
                end
                S_A1:
                begin
                    a1_reg    <= pacc_reg;
                    pbase_reg <= y_reg;
                    pexp_reg  <= u2_reg;
                    pacc_reg  <= one_p;
                    pcnt_reg  <= CNT_W'(MOD_BITS - 1);
                    pret_reg  <= S_A2;
                    state_reg <= S_PSQ;
                end
                S_A2:
                begin
                    req_reg   <= '{start: 1'b1, op: OP_MUL};
                    oa_reg    <= a1_reg;
                    ob_reg    <= pacc_reg;
                    om_reg    <= p_reg;
                    ret_reg   <= S_PROD;
                    state_reg <= S_WAIT;
                end
                S_PROD:
                begin
                    req_reg   <= '{start: 1'b1, op: OP_DIV};
                    oa_reg    <= ar_res;
                    om_reg    <= q_reg;
                    ret_reg   <= S_V;
                    state_reg <= S_WAIT;
                end
                S_V:
                begin
                    v_reg     <= ar_res;
                    // reject r or s of zero or not below q
                    valid_reg <= (cr_reg != '0) && (cr_reg < q_reg) && (cs_reg != '0)
                                 && (cs_reg < q_reg) && (ar_res == cr_reg);
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    // hold until the output register is free
                    if (!ovalid_reg || out_ready)
                    begin
                        ovalid_reg  <= 1'b1;
                        o_y_reg     <= y_reg;
                        o_r_reg     <= sr_reg;
                        o_s_reg     <= ss_reg;
                        o_v_reg     <= v_reg;
                        o_valid_reg <= valid_reg;
                        o_stat_reg  <= stat_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid   = ovalid_reg;
    assign public_key  = o_y_reg;
    assign sig_r       = o_r_reg;
    assign sig_s       = o_s_reg;
    assign check_value = o_v_reg;
    assign valid_res   = o_valid_reg;
    assign status      = o_stat_reg;

endmodule

// ----- sv/dsa_checker.sv -----
`timescale 1ns / 1ps

module dsa_checker import dsa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [MOD_BITS-1:0] sig_r,
    input logic [MOD_BITS-1:0] sig_s,
    input logic [MOD_BITS-1:0] check_value,
    input logic                valid_res,
    input logic                status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> sig_r == '0 && sig_s == '0 && check_value == '0 && !valid_res)
        else $error("error result carries data");

    a_valid_verify: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valid_res |-> sig_r == '0 && sig_s == '0 && check_value != '0)
        else $error("accepted signature with sign fields or zero v");

endmodule

bind dsa_sign_verify_unit dsa_checker u_dsa_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sig_r       (sig_r),
    .sig_s       (sig_s),
    .check_value (check_value),
    .valid_res   (valid_res),
    .status      (status)
);

// ----- tb/dsa_sign_verify_unit_test.sv -----
`timescale 1ns / 1ps

module dsa_sign_verify_unit_test;
    import dsa_pkg::*;

    localparam int IDLE_LIMIT = 200000;
    localparam logic FUNC_SIGN = 1'b0;
    localparam logic FUNC_VERIFY = 1'b1;
    localparam logic [MOD_BITS-1:0] MAX_VAL = {MOD_BITS{1'b1}};

    typedef logic [MOD_BITS-1:0] word_t;

    typedef struct packed
    {
        word_t public_key;
        word_t sig_r;
        word_t sig_s;
        word_t check_value;
        logic  valid_res;
        logic  status;
    } dsa_result_t;

    class dsa_scoreboard;
        longint unsigned p, q, g, x;
        dsa_result_t     awaited[$];
        int              mismatches;
        int              signs, verifies, no_inverse, accepted_sigs;

        function new();
            p = RST_P;
            q = RST_Q;
            g = RST_G;
            x = RST_X;
            mismatches = 0;
            signs = 0;
            verifies = 0;
            no_inverse = 0;
            accepted_sigs = 0;
        endfunction

        function longint unsigned reduce(longint unsigned a, longint unsigned m);
            return (m == 0) ? 0 : a % m;
        endfunction

        function longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                          longint unsigned m);
            return reduce(reduce(a, m) * reduce(b, m), m);
        endfunction

        function longint unsigned pow_mod(longint unsigned base, longint unsigned e,
                                          longint unsigned m);
            longint unsigned acc;
            longint unsigned b;
            acc = reduce(1, m);
            b = reduce(base, m);
            for (int i = 0; i < MOD_BITS; i++)
            begin
                if (e[i])
                    acc = mul_mod(acc, b, m);
                b = mul_mod(b, b, m);
            end
            return acc;
        endfunction

        // Extended Euclid; ok is cleared when no inverse exists.
        function longint unsigned inverse_mod(longint unsigned a, longint unsigned m,
                                              output bit ok);
            longint r0, r1, t0, t1, qt, nr, nt;
            ok = 0;
            if (m < 2)
                return 0;
            r0 = m;
            r1 = reduce(a, m);
            t0 = 0;
            t1 = 1;
            while (r1 != 0)
            begin
                qt = r0 / r1;
                nr = r0 - qt * r1;
                nt = t0 - qt * t1;
                r0 = r1;
                r1 = nr;
                t0 = t1;
                t1 = nt;
            end
            if (r0 != 1)
                return 0;
            if (t0 < 0)
                t0 += m;
            ok = 1;
            return t0;
        endfunction

        function dsa_result_t compute(logic fn, word_t h, word_t k, word_t cr, word_t cs);
            dsa_result_t res;
            longint unsigned y, inv, t, u1, u2, prod;
            bit ok;
            res = '0;
            y = pow_mod(g, x, p);
            res.public_key = word_t'(y);
            if (fn == FUNC_SIGN)
            begin
                inv = inverse_mod(k, q, ok);
                if (ok)
                begin
                    res.sig_r = word_t'(reduce(pow_mod(g, k, p), q));
                    t = reduce(reduce(h, q) + mul_mod(x, res.sig_r, q), q);
                    res.sig_s = word_t'(mul_mod(inv, t, q));
                end
                else
                    res.status = 1'b1;
            end
            else
            begin
                inv = inverse_mod(cs, q, ok);
                if (ok)
                begin
                    u1 = mul_mod(h, inv, q);
                    u2 = mul_mod(cr, inv, q);
                    prod = mul_mod(pow_mod(g, u1, p), pow_mod(y, u2, p), p);
                    res.check_value = word_t'(reduce(prod, q));
                    res.valid_res = (cr != 0 && cr < q && cs != 0 && cs < q
                                     && res.check_value == cr);
                end
                else
                    res.status = 1'b1;
            end
            return res;
        endfunction

        function void note_request(logic fn, word_t h, word_t k, word_t cr, word_t cs);
            dsa_result_t res;
            res = compute(fn, h, k, cr, cs);
            if (fn == FUNC_SIGN)
                signs++;
            else
                verifies++;
            if (res.status)
                no_inverse++;
            if (res.valid_res)
                accepted_sigs++;
            awaited.push_back(res);
        endfunction

        function void check_result(dsa_result_t got);
            dsa_result_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = awaited.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    word_t cfg_data;
    logic in_valid, in_ready;
    logic func;
    word_t hash_value, nonce_k, check_r, check_s;
    logic out_valid, out_ready;
    word_t public_key, sig_r, sig_s, check_value;
    logic valid_res, status;

    dsa_scoreboard sb;
    int idle_cycles;
    int leftover;

    dsa_sign_verify_unit dut
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .hash_value(hash_value), .nonce_k(nonce_k),
        .check_r(check_r), .check_s(check_s),
        .out_valid(out_valid), .out_ready(out_ready),
        .public_key(public_key), .sig_r(sig_r), .sig_s(sig_s),
        .check_value(check_value), .valid_res(valid_res), .status(status)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog: count cycles with no handshake on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("dsa_sign_verify_unit: mismatch");
            $finish;
        end
    end

    // Result side: random stall before each accept.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, 11);
            @(negedge clk);
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            sb.check_result({public_key, sig_r, sig_s, check_value, valid_res, status});
        end
    end

    task automatic send_request(logic fn, word_t h, word_t k, word_t cr, word_t cs);
        int gap;
        gap = $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        func = fn;
        hash_value = h;
        nonce_k = k;
        check_r = cr;
        check_s = cs;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        sb.note_request(fn, h, k, cr, cs);
        // drop the request once taken
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t val);
        @(negedge clk);
        in_valid = 1'b0;
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Hold until every result is back, then load a new group and key.
    task automatic load_group(word_t p, word_t q, word_t g, word_t x);
        while (sb.awaited.size() != 0)
            @(negedge clk);
        write_reg(REG_PRIME_P, p);
        write_reg(REG_ORDER_Q, q);
        write_reg(REG_GENERATOR_G, g);
        write_reg(REG_PRIVATE_X, x);
        sb.p = p;
        sb.q = q;
        sb.g = g;
        sb.x = x;
    endtask

    // Sign, then verify that signature, sometimes with r, s or the hash changed.
    task automatic sign_and_verify();
        word_t h, k;
        dsa_result_t sig;
        h = word_t'($urandom);
        k = (sb.q > 1) ? word_t'($urandom_range(1, sb.q - 1)) : word_t'($urandom);
        send_request(FUNC_SIGN, h, k, word_t'($urandom), word_t'($urandom));
        sig = sb.compute(FUNC_SIGN, h, k, '0, '0);
        case ($urandom_range(0, 5))
            0: sig.sig_r ^= word_t'(1) << $urandom_range(0, MOD_BITS - 1);
            1: sig.sig_s = word_t'($urandom);
            2: h = word_t'($urandom);
            default: ;
        endcase
        send_request(FUNC_VERIFY, h, word_t'($urandom), sig.sig_r, sig.sig_s);
    endtask

    task automatic random_phase(int items);
        word_t big_g;
        int sent;
        big_g = word_t'(sb.pow_mod(7, (MAX_VAL - 1) / 331, MAX_VAL));
        case ($urandom_range(0, 4))
            0: load_group(RST_P, RST_Q, RST_G, word_t'($urandom_range(0, 10)));
            1: load_group(47, 23, 2, word_t'($urandom_range(0, 22)));
            2: load_group(MAX_VAL, 331, big_g, word_t'($urandom_range(0, 330)));
            3: load_group(607, 101, 64, word_t'($urandom_range(0, 100)));
            default: load_group(word_t'($urandom), word_t'($urandom),
                                word_t'($urandom), word_t'($urandom));
        endcase
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                sign_and_verify();
                sent += 2;
            end
            else
            begin
                send_request(1'($urandom_range(0, 1)), word_t'($urandom),
                             word_t'($urandom), word_t'($urandom), word_t'($urandom));
                sent++;
            end
        end
    endtask

    initial
    begin
        dsa_result_t sig;
        sb = new();
        idle_cycles = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        func = FUNC_SIGN;
        hash_value = '0;
        nonce_k = '0;
        check_r = '0;
        check_s = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset group first.
        send_request(FUNC_SIGN, 0, 1, 0, 0);
        send_request(FUNC_SIGN, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL);
        send_request(FUNC_SIGN, 5, 0, 0, 0);
        send_request(FUNC_SIGN, 5, 22, 0, 0);
        sig = sb.compute(FUNC_SIGN, 7, 4, 0, 0);
        send_request(FUNC_VERIFY, 7, 0, sig.sig_r, sig.sig_s);
        send_request(FUNC_VERIFY, 7, 0, 0, sig.sig_s);
        send_request(FUNC_VERIFY, 7, 0, sig.sig_r, 0);
        send_request(FUNC_VERIFY, 7, 0, word_t'(sig.sig_r + 11), sig.sig_s);
        send_request(FUNC_VERIFY, 7, 0, sig.sig_r, word_t'(sig.sig_s + 11));
        send_request(FUNC_VERIFY, MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL);

        // Zero key, zero exponents.
        load_group(47, 23, 2, 0);
        send_request(FUNC_SIGN, 3, 1, 0, 0);
        send_request(FUNC_VERIFY, 0, 0, 1, 1);
        // Widest values for the group and key.
        load_group(MAX_VAL, MAX_VAL, MAX_VAL, MAX_VAL);
        send_request(FUNC_SIGN, MAX_VAL, 12345, 0, 0);
        send_request(FUNC_VERIFY, MAX_VAL, 0, word_t'(MAX_VAL - 1), word_t'(MAX_VAL - 1));
        // Order below two: no inverse ever.
        load_group(23, 1, 2, 3);
        send_request(FUNC_SIGN, 9, 3, 0, 0);
        send_request(FUNC_VERIFY, 9, 0, 1, 1);
        load_group(23, 0, 2, 3);
        send_request(FUNC_SIGN, 9, 3, 0, 0);
        // Composite order and zero generator.
        load_group(23, 12, 0, 5);
        send_request(FUNC_SIGN, 4, 6, 0, 0);
        send_request(FUNC_SIGN, 4, 5, 0, 0);
        send_request(FUNC_VERIFY, 4, 0, 3, 7);

        for (int ph = 0; ph < 6; ph++)
            random_phase(21);

        while (sb.awaited.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        leftover = sb.awaited.size();
        $display("covered %0d sign and %0d verify requests, %0d without inverse,",
                 sb.signs, sb.verifies, sb.no_inverse);
        $display("%0d signatures accepted, %0d mismatches", sb.accepted_sigs, sb.mismatches);
        if (sb.mismatches == 0 && leftover == 0)
            $display("dsa_sign_verify_unit: match");
        else
            $display("dsa_sign_verify_unit: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/dsa_pkg.sv
sv/dsa_arith.sv
sv/dsa_sign_verify_unit.sv
sv/dsa_checker.sv
tb/dsa_sign_verify_unit_test.sv
